/* design/ca_majority_class_smoothing_top_macros.svh */
// Assertion macros shared by the majority smoothing RTL
`ifndef CA_MAJORITY_CLASS_SMOOTHING_TOP_MACROS_SVH
`define CA_MAJORITY_CLASS_SMOOTHING_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define CAMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition leads to a result in the next clock cycle
`define CAMS_ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error(msg);

`endif

/* design/cams_pkg.sv */
// Shared types and constants for the majority smoothing block
`timescale 1ns / 1ps
`default_nettype none

package cams_pkg;

    localparam int CELL_W            = 2;
    localparam int FRAME_WIDTH_W     = 10;
    localparam int FRAME_HEIGHT_W    = 11;
    localparam int ROW_W             = 12;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int DEFAULT_MAX_WIDTH = 512;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 10'd450;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 11'd200;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CELL_W-1:0] CLASS_EMPTY  = 2'd0;
    localparam logic [CELL_W-1:0] CLASS_ROCK   = 2'd1;
    localparam logic [CELL_W-1:0] CLASS_JUNGLE = 2'd2;
    localparam logic [CELL_W-1:0] CLASS_HELL   = 2'd3;

    localparam logic [3:0] SUM_SPLIT = 4'd4;

    typedef struct packed {
        logic              out_valid;
        logic [CELL_W-1:0] result_value;
        logic              frame_end;
    } result_t;

endpackage

`default_nettype wire

/* design/cams_line_buf.sv */
// Two line stores with one-column read-ahead and write bypass
`timescale 1ns / 1ps
`default_nettype none

module cams_line_buf #(
    parameter int MAX_WIDTH = cams_pkg::DEFAULT_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic                      clk,
    input  wire logic                      step,
    input  wire logic [COL_W-1:0]          wr_addr,
    input  wire logic [COL_W-1:0]          rd_addr,
    input  wire logic [cams_pkg::CELL_W-1:0] cell_in,
    output logic      [cams_pkg::CELL_W-1:0] upper,
    output logic      [cams_pkg::CELL_W-1:0] lower
);
    import cams_pkg::*;

    logic [CELL_W-1:0] mem_upper [MAX_WIDTH];
    logic [CELL_W-1:0] mem_lower [MAX_WIDTH];
    logic [CELL_W-1:0] upper_reg;
    logic [CELL_W-1:0] lower_reg;
    logic              bypass;

    assign bypass = step && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            mem_upper[wr_addr] <= lower_reg;
            mem_lower[wr_addr] <= cell_in;
        end
    end

    // fetch the column the next request will use
    always_ff @(posedge clk)
    begin
        if (bypass)
        begin
            upper_reg <= lower_reg;
            lower_reg <= cell_in;
        end
        else
        begin
            upper_reg <= mem_upper[rd_addr];
            lower_reg <= mem_lower[rd_addr];
        end
    end

    assign upper = upper_reg;
    assign lower = lower_reg;

endmodule

`default_nettype wire

/* design/cams_rule.sv */
// Neighbour class count and majority decision for one window
`timescale 1ns / 1ps
`default_nettype none

module cams_rule (
    input  wire logic [8:0][cams_pkg::CELL_W-1:0] window,
    input  wire logic [cams_pkg::CELL_W-1:0]      left_value,
    input  wire logic                             border,
    output logic      [cams_pkg::CELL_W-1:0]      rule_value
);
    import cams_pkg::*;

    logic [3:0] cnt_rock;
    logic [3:0] cnt_jungle;
    logic [3:0] cnt_hell;
    logic [3:0] sum;

    always_comb
    begin
        cnt_rock   = '0;
        cnt_jungle = '0;
        cnt_hell   = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                cnt_rock   = cnt_rock   + 4'(window[i] == CLASS_ROCK);
                cnt_jungle = cnt_jungle + 4'(window[i] == CLASS_JUNGLE);
                cnt_hell   = cnt_hell   + 4'(window[i] == CLASS_HELL);
            end
        end
        sum = cnt_rock + cnt_jungle + cnt_hell;
    end

    always_comb
    begin
        if (border)
            rule_value = CLASS_EMPTY;
        else if (sum > SUM_SPLIT)
        begin
            if (cnt_hell >= cnt_rock && cnt_hell >= cnt_jungle)
                rule_value = CLASS_HELL;
            else if (cnt_jungle >= cnt_rock && cnt_jungle >= cnt_hell)
                rule_value = CLASS_JUNGLE;
            else
                rule_value = CLASS_ROCK;
        end
        else if (sum < SUM_SPLIT)
            rule_value = CLASS_EMPTY;
        else
            rule_value = left_value;
    end

endmodule

`default_nettype wire

/* design/cams_out_buf.sv */
// Two-entry result buffer between the window logic and the result channel
`timescale 1ns / 1ps
`default_nettype none

`include "ca_majority_class_smoothing_top_macros.svh"

module cams_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cams_pkg::result_t push_data,
    output logic                   space,
    output logic                   head_valid,
    input  wire logic              pop_ready,
    output cams_pkg::result_t      head
);
    import cams_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign pop        = head_valid && pop_ready;
    assign head_valid = (count_reg != 2'd0);
    assign space      = (count_reg != 2'd2);
    assign head       = head_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && count_reg == 2'd1)
                head_reg <= push_data;
            else
                head_reg <= tail_reg;
            if (push && count_reg == 2'd2)
                tail_reg <= push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                head_reg <= push_data;
            else
                tail_reg <= push_data;
        end
    end

    `CAMS_ASSERT(a_count_range, clk, rst_n, count_reg != 2'd3, "result buffer overflow")
    `CAMS_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + 2'd1, "result buffer lost a request")

endmodule

`default_nettype wire

/* design/ca_majority_class_smoothing_top.sv */
// Top level of the majority class smoothing block: counters, window and config
`timescale 1ns / 1ps
`default_nettype none

`include "ca_majority_class_smoothing_top_macros.svh"

// One generation of a four-class majority automaton over a raster frame. Cells go in
// on the cell channel in raster order, one request per clock when not stalled; each
// frame is width*height cells followed by width+1 pad cells whose values are ignored.
// Every request pushes exactly one result into the result buffer, for the cell width+1
// positions earlier; out_valid marks real frame cells and frame_end the last one.
// Sustained rate is one cell per clock while results drain: the two line stores are
// single memories read one column ahead, so each store does one read and one write
// per cell. A two-entry result buffer keeps cells flowing while results stall, until
// full. Writing frame_width or frame_height restarts the frame position.
module ca_majority_class_smoothing_top #(
    parameter int MAX_WIDTH = cams_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cell_valid,
    output logic                                     cell_ready,
    input  wire logic [cams_pkg::CELL_W-1:0]         cell_value,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic                                     out_valid,
    output logic      [cams_pkg::CELL_W-1:0]         result_value,
    output logic                                     frame_end,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cams_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [cams_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [cams_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);
    import cams_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = (FRAME_WIDTH_W > $clog2(MAX_WIDTH + 1)) ?
                           FRAME_WIDTH_W : $clog2(MAX_WIDTH + 1);

    logic [FRAME_WIDTH_W-1:0]  fw_reg;
    logic [FRAME_HEIGHT_W-1:0] fh_reg;
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          col_next;
    logic [COL_W-1:0]          col_d;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [8:0][CELL_W-1:0]    win_reg;
    logic [8:0][CELL_W-1:0]    win_next;
    logic [CELL_W-1:0]         left_reg;

    logic                      cfg_wr;
    logic                      step;
    logic [EW-1:0]             fw_ext;
    logic [EW-1:0]             eff_w;
    logic [ROW_W-1:0]          fh_ext;
    logic [ROW_W-1:0]          eff_h;
    logic [EW-1:0]             col_ext;
    logic [EW-1:0]             col_inc;
    logic                      c_zero;
    logic                      valid_c;
    logic [ROW_W-1:0]          orow;
    logic [EW-1:0]             ocol;
    logic                      border;
    logic                      restart;
    logic [CELL_W-1:0]         cell_in;
    logic [CELL_W-1:0]         upper;
    logic [CELL_W-1:0]         lower;
    logic [CELL_W-1:0]         rule_value;
    result_t                   res_c;
    result_t                   head;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(fw_reg);
            REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(fh_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RESET;
            fh_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  fw_reg <= pwdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: fh_reg <= pwdata[FRAME_HEIGHT_W-1:0];
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    // effective frame size
    assign fw_ext = EW'(fw_reg);
    assign fh_ext = ROW_W'(fh_reg);

    always_comb
    begin
        if (fw_ext < EW'(3))
            eff_w = EW'(3);
        else if (fw_ext > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = fw_ext;
        eff_h = (fh_ext < ROW_W'(3)) ? ROW_W'(3) : fh_ext;
    end

    // position of the cell being produced
    assign step    = cell_valid && cell_ready;
    assign col_ext = EW'(col_reg);
    assign col_inc = col_ext + EW'(1);
    assign c_zero  = (col_reg == '0);
    assign valid_c = c_zero ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
    assign orow    = c_zero ? row_reg - ROW_W'(2) : row_reg - ROW_W'(1);
    assign ocol    = c_zero ? eff_w - EW'(1) : col_ext - EW'(1);
    assign border  = (orow == '0) || (orow == eff_h - ROW_W'(1))
                  || (ocol == '0) || (ocol == eff_w - EW'(1));
    assign restart = c_zero && (row_reg == eff_h + ROW_W'(1));
    assign cell_in = (row_reg < eff_h) ? cell_value : CLASS_EMPTY;

    always_comb
    begin
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_comb
    begin
        if (cfg_wr)
            col_d = '0;
        else if (step)
            col_d = col_next;
        else
            col_d = col_reg;
    end

    // advance the window by one column
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            win_next[a*3]     = win_reg[a*3 + 1];
            win_next[a*3 + 1] = win_reg[a*3 + 2];
        end
        win_next[2] = upper;
        win_next[5] = lower;
        win_next[8] = cell_in;
    end

    cams_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_buf (
        .clk     (clk),
        .step    (step),
        .wr_addr (col_reg),
        .rd_addr (col_d),
        .cell_in (cell_in),
        .upper   (upper),
        .lower   (lower)
    );

    cams_rule u_rule (
        .window     (win_next),
        .left_value (left_reg),
        .border     (border),
        .rule_value (rule_value)
    );

    always_comb
    begin
        res_c.out_valid    = valid_c;
        res_c.result_value = valid_c ? rule_value : CLASS_EMPTY;
        res_c.frame_end    = valid_c && (orow == eff_h - ROW_W'(1))
                          && (ocol == eff_w - EW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            win_reg  <= '0;
            left_reg <= CLASS_EMPTY;
        end
        else if (cfg_wr)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            win_reg  <= '0;
            left_reg <= CLASS_EMPTY;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= win_next;
            if (valid_c)
                left_reg <= rule_value;
        end
    end

    cams_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (res_c),
        .space      (cell_ready),
        .head_valid (result_valid),
        .pop_ready  (result_ready),
        .head       (head)
    );

    assign out_valid    = head.out_valid;
    assign result_value = head.result_value;
    assign frame_end    = head.frame_end;

    `CAMS_ASSERT(a_col_in_row, clk, rst_n, col_ext < eff_w, "column beyond frame width")
    `CAMS_ASSERT(a_row_in_frame, clk, rst_n, row_reg <= eff_h + ROW_W'(1),
        "row beyond frame and pad")
    `CAMS_ASSERT_NEXT(a_restart, clk, rst_n, step && restart,
        (row_reg == '0) && (col_reg == '0), "frame did not restart after pad")

endmodule

`default_nettype wire
